/* design/sip_pkg.sv */
// ============================================================================
// Segment intersection point package
// Shared output width parameter of the intersection unit.
// ============================================================================
package sip_pkg;

    // Fixed output width of the intersection coordinates.
    localparam int unsigned OUT_BITS = 32;

endpackage

/* design/segment_intersection_point_unit.sv */
// ============================================================================
// Segment intersection point unit
// Cross products, a chain of restoring division cells and point scaling.
// ============================================================================
// Registers from start to o_strobe: differences, products, cross products, division cells, point stages A and B.
// Throughput: one item per cycle; busy is always low.
// The depth is set by the division chain, one quotient bit per cell.
// Reset clears all valid flags; results in flight are dropped.
// The receiver cannot stall; each result shows for one cycle.
module segment_intersection_point_unit #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by_coord,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_dx,
    input  logic signed [COORD_BITS-1:0] i_dy,
    output logic                         o_strobe,
    output logic                         o_hit,
    output logic signed [sip_pkg::OUT_BITS-1:0] o_ix,
    output logic signed [sip_pkg::OUT_BITS-1:0] o_iy
);

    localparam int unsigned DW = COORD_BITS + 1;     // difference width
    localparam int unsigned PW = 2 * DW;             // product width
    localparam int unsigned CW = PW + 1;             // cross product width
    localparam int unsigned QW = FRAC_BITS + 2;      // quotient width
    localparam int unsigned AW = COORD_BITS + FRAC_BITS + 2; // point width
    localparam int unsigned YW = 2 * COORD_BITS;     // payload width
    localparam int unsigned MW = DW + QW + 1;        // product width, point

    // Stage 1: differences.
    logic                 r_v1;
    logic signed [DW-1:0] r_abx, r_aby, r_acx, r_acy, r_cdx, r_cdy;
    logic signed [COORD_BITS-1:0] r_ax1, r_ay1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else r_v1 <= start;
    end

    always_ff @(posedge i_clk) begin
        r_abx <= DW'(i_bx) - DW'(i_ax);
        r_aby <= DW'(i_by_coord) - DW'(i_ay);
        r_acx <= DW'(i_cx) - DW'(i_ax);
        r_acy <= DW'(i_cy) - DW'(i_ay);
        r_cdx <= DW'(i_dx) - DW'(i_cx);
        r_cdy <= DW'(i_dy) - DW'(i_cy);
        r_ax1 <= i_ax;
        r_ay1 <= i_ay;
    end

    // Stage 2: the six products.
    logic                 r_v2;
    logic signed [PW-1:0] r_p1a, r_p1b, r_p2a, r_p2b, r_p3a, r_p3b;
    logic signed [DW-1:0] r_abx2, r_aby2;
    logic signed [COORD_BITS-1:0] r_ax2, r_ay2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        r_p1a  <= PW'(r_acx) * PW'(r_cdy);
        r_p1b  <= PW'(r_acy) * PW'(r_cdx);
        r_p2a  <= PW'(r_abx) * PW'(r_cdy);
        r_p2b  <= PW'(r_aby) * PW'(r_cdx);
        r_p3a  <= PW'(r_acx) * PW'(r_aby);
        r_p3b  <= PW'(r_acy) * PW'(r_abx);
        r_abx2 <= r_abx;
        r_aby2 <= r_aby;
        r_ax2  <= r_ax1;
        r_ay2  <= r_ay1;
    end

    // Stage 3: cross products, sign fold and the hit test.
    logic signed [CW-1:0] n_c1, n_c2, n_c3, n_f1, n_f2, n_f3;
    logic                 n_hit;
    logic                 r_v3;
    logic                 r_hit3;
    logic [CW:0]          r_rem3;
    logic [CW-1:0]        r_den3;
    logic [YW-1:0]        r_pay3;

    always_comb begin
        n_c1 = CW'(r_p1a) - CW'(r_p1b);
        n_c2 = CW'(r_p2a) - CW'(r_p2b);
        n_c3 = CW'(r_p3a) - CW'(r_p3b);
        if (n_c2 < 0) begin
            n_f1 = -n_c1;
            n_f2 = -n_c2;
            n_f3 = -n_c3;
        end else begin
            n_f1 = n_c1;
            n_f2 = n_c2;
            n_f3 = n_c3;
        end
        n_hit = (n_f2 != '0) && (n_f1 >= 0) && (n_f1 <= n_f2)
              && (n_f3 >= 0) && (n_f3 <= n_f2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else r_v3 <= r_v2;
    end

    // The first division step is the integer bit: c1 >= c2.
    always_ff @(posedge i_clk) begin
        r_hit3 <= n_hit;
        r_den3 <= n_f2;
        r_pay3 <= {r_ax2, r_ay2};
        if (n_f1 >= n_f2) r_rem3 <= (CW+1)'(n_f1 - n_f2);
        else r_rem3 <= (CW+1)'(n_f1);
    end

    // Division chain: one cell per fraction bit. The payload carries the hit flag,
    // the start point and both axis deltas through the cells' payload registers.
    logic [FRAC_BITS:0]           w_vld;
    logic [CW:0]                  w_rem [FRAC_BITS+1];
    logic [CW-1:0]                w_den [FRAC_BITS+1];
    logic [QW-1:0]                w_quo [FRAC_BITS+1];
    logic [2*DW+2*COORD_BITS:0]   w_pay [FRAC_BITS+1];
    logic                         r_q0;
    logic signed [DW-1:0]         r_abx3, r_aby3;

    always_ff @(posedge i_clk) begin
        r_abx3 <= r_abx2;
        r_aby3 <= r_aby2;
        r_q0   <= (n_f1 >= n_f2);
    end

    assign w_vld[0] = r_v3;
    assign w_rem[0] = r_rem3;
    assign w_den[0] = r_den3;
    assign w_quo[0] = {{(QW-1){1'b0}}, r_q0};
    assign w_pay[0] = {r_hit3, r_pay3, r_abx3, r_aby3};

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_cell
        sip_div_cell #(
            .CW (CW),
            .QW (QW),
            .PW (2*DW+2*COORD_BITS+1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_rem   (w_rem[g]),
            .i_den   (w_den[g]),
            .i_quo   (w_quo[g]),
            .i_pay   (w_pay[g]),
            .o_vld   (w_vld[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_den[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_pay   (w_pay[g+1])
        );
    end

    // Point stage A: the delta products.
    logic [2*DW+2*COORD_BITS:0] n_pay;
    logic signed [DW-1:0]       n_dxa, n_dya;
    logic signed [COORD_BITS-1:0] n_axa, n_aya;
    logic signed [QW:0]         n_t;
    logic                       r_v4, r_hit4;
    logic signed [MW-1:0]       r_mx, r_my;
    logic signed [COORD_BITS-1:0] r_ax4, r_ay4;

    assign n_pay = w_pay[FRAC_BITS];
    assign n_aya = n_pay[2*DW+COORD_BITS-1 -: COORD_BITS];
    assign n_axa = n_pay[2*DW+2*COORD_BITS-1 -: COORD_BITS];
    assign n_dxa = n_pay[2*DW-1 -: DW];
    assign n_dya = n_pay[DW-1:0];
    assign n_t   = {1'b0, w_quo[FRAC_BITS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else r_v4 <= w_vld[FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        r_hit4 <= n_pay[2*DW+2*COORD_BITS];
        r_mx   <= MW'(n_dxa) * MW'(n_t);
        r_my   <= MW'(n_dya) * MW'(n_t);
        r_ax4  <= n_axa;
        r_ay4  <= n_aya;
    end

    // Point stage B: add the scaled start point and gate on hit.
    logic signed [AW+DW:0] n_px, n_py;
    logic                  r_v5, r_hit5;
    logic signed [sip_pkg::OUT_BITS-1:0] r_ix, r_iy;

    assign n_px = ((AW+DW+1)'(r_ax4) <<< FRAC_BITS) + (AW+DW+1)'(r_mx);
    assign n_py = ((AW+DW+1)'(r_ay4) <<< FRAC_BITS) + (AW+DW+1)'(r_my);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else r_v5 <= r_v4;
    end

    always_ff @(posedge i_clk) begin
        r_hit5 <= r_hit4;
        r_ix   <= r_hit4 ? n_px[sip_pkg::OUT_BITS-1:0] : '0;
        r_iy   <= r_hit4 ? n_py[sip_pkg::OUT_BITS-1:0] : '0;
    end

    assign busy     = 1'b0;
    assign o_strobe = r_v5;
    assign o_hit    = r_hit5;
    assign o_ix     = r_ix;
    assign o_iy     = r_iy;

endmodule

/* design/sip_div_cell.sv */
// ============================================================================
// Division cell
// One restoring quotient step; carries the item's payload to the next cell.
// ============================================================================
module sip_div_cell #(
    parameter int unsigned CW = 36,
    parameter int unsigned QW = 18,
    parameter int unsigned PW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [CW:0]   i_rem,
    input  logic [CW-1:0] i_den,
    input  logic [QW-1:0] i_quo,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [CW:0]   o_rem,
    output logic [CW-1:0] o_den,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic [CW+1:0] n_shift;
    logic [CW+1:0] n_diff;
    logic          r_vld;
    logic [CW:0]   r_rem;
    logic [CW-1:0] r_den;
    logic [QW-1:0] r_quo;
    logic [PW-1:0] r_pay;

    // Shift the remainder and try a subtraction of the divisor.
    assign n_shift = {i_rem, 1'b0};
    assign n_diff  = n_shift - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= i_den;
        r_pay <= i_pay;
        if (!n_diff[CW+1]) begin
            r_rem <= n_diff[CW:0];
            r_quo <= {i_quo[QW-2:0], 1'b1};
        end else begin
            r_rem <= n_shift[CW:0];
            r_quo <= {i_quo[QW-2:0], 1'b0};
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_pay = r_pay;

endmodule

/* design/sip_checker.sv */
// ============================================================================
// Intersection unit port checker
// Watches the ports for busy, result timing and miss encoding.
// ============================================================================
module sip_checker #(
    parameter int unsigned FRAC_BITS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic        o_hit,
    input logic [31:0] o_ix,
    input logic [31:0] o_iy
);

    // The unit never refuses an item.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // A miss reports a zero point.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> (o_ix == '0 && o_iy == '0))
        else $error("miss with nonzero point");

    // Every result traces back to an accepted item.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, FRAC_BITS + 5))
        else $error("result without item");

endmodule

bind segment_intersection_point_unit sip_checker #(.FRAC_BITS(FRAC_BITS)) u_sip_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_hit    (o_hit),
    .o_ix     (o_ix),
    .o_iy     (o_iy)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection point unit testbench
// Sends segment pairs through the input ports and checks every result
// against an inline predictor. A directed table covers the special cases,
// and random pairs with idle bursts follow it.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW = 16;
    localparam int FW = 16;
    localparam int LATENCY = FW + 5;
    localparam int N_RANDOM = 530;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic        hit;
        logic [31:0] ix;
        logic [31:0] iy;
    } t_point;

    // One row of the directed table; chk marks a typed-in expectation.
    typedef struct {
        t_coord ax, ay, bx, by, cx, cy, dx, dy;
        bit     chk;
        t_point pt;
    } t_row;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_coord i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy, i_dx, i_dy;
    logic   o_strobe;
    logic   o_hit;
    logic signed [sip_pkg::OUT_BITS-1:0] o_ix, o_iy;

    t_point pending_points[$];
    int     n_errors = 0;

    segment_intersection_point_unit #(.COORD_BITS(CW), .FRAC_BITS(FW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by_coord(i_by_coord),
        .i_cx(i_cx), .i_cy(i_cy), .i_dx(i_dx), .i_dy(i_dy),
        .o_strobe(o_strobe), .o_hit(o_hit), .o_ix(o_ix), .o_iy(o_iy)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Computes the crossing point of segments A-B and C-D.
    function automatic t_point crossing_point(t_coord ax, t_coord ay, t_coord bx,
                                              t_coord by, t_coord cx, t_coord cy,
                                              t_coord dx, t_coord dy);
        longint abx, aby, acx, acy, cdx, cdy, c1, c2, c3, q, r, px, py;
        t_point p;
        abx = longint'(bx) - ax;  aby = longint'(by) - ay;
        acx = longint'(cx) - ax;  acy = longint'(cy) - ay;
        cdx = longint'(dx) - cx;  cdy = longint'(dy) - cy;
        c1 = acx * cdy - acy * cdx;
        c2 = abx * cdy - aby * cdx;
        c3 = acx * aby - acy * abx;
        if (c2 < 0) begin
            c1 = -c1;  c2 = -c2;  c3 = -c3;
        end
        p = '0;
        if (c2 != 0 && c1 >= 0 && c1 <= c2 && c3 >= 0 && c3 <= c2) begin
            // Restoring division, one quotient bit per step.
            q = 0;
            r = c1;
            if (r >= c2) begin
                q = 1;
                r -= c2;
            end
            for (int i = 0; i < FW; i++) begin
                r = r <<< 1;
                q = q <<< 1;
                if (r >= c2) begin
                    r -= c2;
                    q |= 1;
                end
            end
            px = longint'(ax) * (longint'(1) <<< FW) + abx * q;
            py = longint'(ay) * (longint'(1) <<< FW) + aby * q;
            p.hit = 1'b1;
            p.ix = px[31:0];
            p.iy = py[31:0];
        end
        return p;
    endfunction

    // Checks each strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_strobe) begin
            if (pending_points.size() == 0) begin
                $error("result with no item outstanding: hit=%0b", o_hit);
                n_errors++;
            end else begin
                want = pending_points.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0b, actual %0b", want.hit, o_hit);
                    n_errors++;
                end
                if (o_ix !== want.ix) begin
                    $error("ix: expected %0h, actual %0h", want.ix, o_ix);
                    n_errors++;
                end
                if (o_iy !== want.iy) begin
                    $error("iy: expected %0h, actual %0h", want.iy, o_iy);
                    n_errors++;
                end
            end
        end
    end

    // Drives one item and waits for it to be accepted.
    task automatic send_item(t_row r);
        t_point p;
        p = crossing_point(r.ax, r.ay, r.bx, r.by, r.cx, r.cy, r.dx, r.dy);
        if (r.chk && p !== r.pt) begin
            $error("table row disagrees with predictor: hit=%0b", r.pt.hit);
            n_errors++;
        end
        start      <= 1'b1;
        i_ax       <= r.ax;  i_ay <= r.ay;
        i_bx       <= r.bx;  i_by_coord <= r.by;
        i_cx       <= r.cx;  i_cy <= r.cy;
        i_dx       <= r.dx;  i_dy <= r.dy;
        do @(posedge i_clk); while (busy);
        pending_points.push_back(r.chk ? r.pt : p);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord(int span);
        if (span == 0)
            return t_coord'($urandom);
        return t_coord'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Builds a random pair, half the time crossing segments around a common point.
    function automatic t_row rand_row();
        t_row r;
        int   span, mode;
        t_coord px, py;
        mode = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(2, 14));
        r = '{default: '0};
        r.ax = rand_coord(span);  r.ay = rand_coord(span);
        r.bx = rand_coord(span);  r.by = rand_coord(span);
        r.cx = rand_coord(span);  r.cy = rand_coord(span);
        r.dx = rand_coord(span);  r.dy = rand_coord(span);
        if (mode < 5) begin
            // Segments through opposite points around a common center.
            px = rand_coord(span == 0 ? 16000 : span);
            py = rand_coord(span == 0 ? 16000 : span);
            r.bx = t_coord'(2 * px - r.ax);  r.by = t_coord'(2 * py - r.ay);
            r.dx = t_coord'(2 * px - r.cx);  r.dy = t_coord'(2 * py - r.cy);
        end else if (mode == 5) begin
            // Parallel pair.
            r.dx = t_coord'(r.cx + (r.bx - r.ax));
            r.dy = t_coord'(r.cy + (r.by - r.ay));
        end else if (mode == 6) begin
            // Shared endpoint.
            r.cx = r.bx;  r.cy = r.by;
        end
        return r;
    endfunction

    localparam t_point MISS = '{hit: 1'b0, ix: 32'd0, iy: 32'd0};
    localparam t_coord MAXC = t_coord'(16'sh7fff);
    localparam t_coord MINC = t_coord'(16'sh8000);

    // Directed rows: ax ay bx by cx cy dx dy, typed expectation where obvious.
    t_row directed_rows[] = '{
        '{-4, 0, 4, 0, 0, -4, 0, 4, 1, '{1'b1, 32'd0, 32'd0}},
        '{0, 0, 4, 4, 0, 4, 4, 0, 1, '{1'b1, 32'h20000, 32'h20000}},
        '{0, 0, 4, 0, 0, 1, 4, 1, 1, MISS},
        '{0, 0, 4, 0, 1, 0, 3, 0, 1, MISS},
        '{1, 1, 1, 1, 0, 0, 4, 4, 1, MISS},
        '{0, 0, 4, 0, 5, -1, 5, 1, 1, MISS},
        '{0, 0, 4, 0, 4, 0, 4, 5, 1, '{1'b1, 32'h40000, 32'd0}},
        '{0, 0, 4, 0, 0, 0, 0, 5, 1, '{1'b1, 32'd0, 32'd0}},
        '{0, 0, 3, 1, 1, 0, 1, 7, 0, MISS},
        '{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, 0, MISS},
        '{MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, 0, MISS},
        '{MINC, 0, MAXC, 0, 0, MINC, 0, MAXC, 0, MISS},
        '{MINC, MINC, MINC, MAXC, MINC, 0, MAXC, 0, 0, MISS},
        '{MAXC, MAXC, MAXC, MAXC, MINC, MINC, MAXC, MAXC, 1, MISS},
        '{-1, -1, -1, -1, -1, -1, -1, -1, 1, MISS},
        '{0, 0, 0, 0, 0, 0, 0, 0, 1, MISS},
        '{MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, 1, MISS},
        '{-3, 7, 11, -2, 5, -9, -1, 13, 0, MISS},
        '{21845, -21846, -21846, 21845, -1, -1, 1, 1, 0, MISS}
    };

    // Main stimulus.
    initial begin
        t_row r;
        int   n;
        start = 1'b0;
        i_rst_n = 1'b0;
        {i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy, i_dx, i_dy} = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) send_item(directed_rows[k]);
        start <= 1'b0;

        // Hold off until every outstanding result has come back.
        while (pending_points.size() != 0) @(posedge i_clk);

        for (n = 0; n < N_RANDOM; n++) begin
            r = rand_row();
            send_item(r);
            if (n < N_RANDOM - 80 && $urandom_range(0, 4) == 0)
                idle_burst();
        end
        start <= 1'b0;

        n = 0;
        while (pending_points.size() != 0 && n < 10 * LATENCY) begin
            @(posedge i_clk);
            n++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (n_errors == 0 && pending_points.size() == 0)
            $display("segment_intersection_point_unit: match");
        else
            $display("segment_intersection_point_unit: mismatch");
        $finish;
    end

    // Run limit.
    initial begin
        #2ms;
        $display("segment_intersection_point_unit: mismatch");
        $finish;
    end

endmodule

/* files.f */
design/sip_pkg.sv
design/sip_div_cell.sv
design/segment_intersection_point_unit.sv
design/sip_checker.sv
dv/tb.sv
